[rtl/clpc_pkg.sv]
// Shared types, codes and constants for the card layer pixel compositor.
package clpc_pkg;

    // Frame store geometry
    localparam int FRAME_PIXELS = 1048576;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);

    // Operation codes; any other code reads the pixel
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_COMPOSITE = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    // Layer codes
    localparam logic [1:0] LAYER_COLOR   = 2'd0;
    localparam logic [1:0] LAYER_BLACK   = 2'd1;
    localparam logic [1:0] LAYER_INHIBIT = 2'd2;
    localparam logic [1:0] LAYER_UV      = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TRANSPARENT = 1'b0;
    localparam logic CFG_UV_NO_INK   = 1'b1;

    // Arithmetic constants
    localparam logic [9:0]  DARK_SUM   = 10'd384;      // 3 * 128
    localparam logic [7:0]  BLACK_MIN_A = 8'h80;       // source alpha must exceed this
    localparam logic [7:0]  UV_ALPHA_CAP = 8'h80;
    localparam logic [7:0]  UV_TINT    = 8'h99;
    localparam logic [7:0]  FULL       = 8'hFF;
    // ceil(2^32 / 2295): exact quotient for any square of a 10-bit sum
    localparam logic [20:0] SQ_RECIP   = 21'd1871446;
    // ceil(2^24 / 255): exact quotient for products up to 255 * 153
    localparam logic [16:0] UV_RECIP   = 17'd65794;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  layer;
        logic [19:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_item;

    // Stored pixel word: alpha in 31:24, blue 23:16, green 15:8, red 7:0
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic transparent_preview;
        logic uv_without_ink;
    } t_cfg;

endpackage

[rtl/card_layer_pixel_compositor_top.sv]
// Top level: item handshake, sequencer, configuration and output register.
//
// Each transfer moves through the idle, compute and done states: the frame
// store is read in the accept cycle, the compute state forms the brightness
// square and tint products, and the done state divides by reciprocal
// multiply, writes the pixel back and loads the output register. A new item
// is taken only once the sequencer is back in idle, so the block does not
// accept a new item before the last one has finished. A finished result
// waits in the output register while the next item is accepted; the last
// stage stalls only if that register is still full. The frame store has no
// reset or clearing pass: a pixel must be written before it is read.
// Addresses at or beyond the store size change nothing and return zero.
module card_layer_pixel_compositor_top
    import clpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_in_item  r_item;
    logic      r_in_range;
    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      in_xfer;
    logic      finish;
    logic      in_range;
    logic      store_we;
    t_pixel    rd_px;
    t_pixel    blend_px;
    t_pixel    res_px;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_in_item.pixel_index) < 32'(FRAME_PIXELS));
    assign finish     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Sequence one item through read, compute and write back
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_CALC;
            S_CALC:  n_state = S_DONE;
            S_DONE:  if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item     <= i_in_item;
            r_in_range <= in_range;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRANSPARENT: r_cfg.transparent_preview <= i_cfg_data;
                CFG_UV_NO_INK:   r_cfg.uv_without_ink      <= i_cfg_data;
                default:         r_cfg                     <= r_cfg;
            endcase
        end
    end

    clpc_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer && in_range),
        .i_rd_addr (ADDR_W'(i_in_item.pixel_index)),
        .o_rd_data (rd_px),
        .i_wr_en   (store_we),
        .i_wr_addr (ADDR_W'(r_item.pixel_index)),
        .i_wr_data (res_px)
    );

    clpc_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (r_state == S_CALC),
        .i_item (r_item),
        .i_px   (rd_px),
        .i_cfg  (r_cfg),
        .o_px   (blend_px)
    );

    // Select the pixel after this item
    always_comb begin
        if (!r_in_range) begin
            res_px = '0;
        end else if (r_item.op == OP_WRITE) begin
            res_px = '{alpha: r_item.alpha, blue: r_item.blue,
                       green: r_item.green, red: r_item.red};
        end else if (r_item.op == OP_COMPOSITE) begin
            res_px = blend_px;
        end else begin
            res_px = rd_px;
        end
    end

    // Write back only items that change the pixel
    assign store_we = finish && r_in_range &&
                      ((r_item.op == OP_WRITE) || (r_item.op == OP_COMPOSITE));

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_item <= '{out_red: res_px.red, out_green: res_px.green,
                            out_blue: res_px.blue, out_alpha: res_px.alpha};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_write_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_we |-> (r_state == S_DONE))
        else $error("frame store written outside the final stage");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CALC))
        else $error("accepted item did not enter compute");

    a_calc_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |=> (r_state == S_DONE))
        else $error("compute stage did not advance");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished item");

endmodule

[rtl/clpc_store.sv]
// Frame store: single-port-write, registered-read pixel memory.
module clpc_store
    import clpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_pixel            o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_pixel            i_wr_data
);

    t_pixel r_mem [FRAME_PIXELS];
    t_pixel r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/clpc_blend.sv]
// Layer blend datapath: squares and tint products, then reciprocal divide and merge.
module clpc_blend
    import clpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_en,
    input  t_in_item i_item,
    input  t_pixel   i_px,
    input  t_cfg     i_cfg,
    output t_pixel   o_px
);

    logic [9:0]  sum;
    logic [19:0] n_sq;
    logic [15:0] n_g153;
    logic [15:0] n_b153;
    logic [19:0] r_sq;
    logic [15:0] r_g153;
    logic [15:0] r_b153;
    logic [40:0] sq_prod;
    logic [32:0] g_prod;
    logic [32:0] b_prod;
    logic [7:0]  quot;
    logic [7:0]  fade;
    logic [7:0]  uv_g;
    logic [7:0]  uv_b;
    logic        dark;
    t_pixel      px;

    // Stage one: brightness square and inverted tint products
    assign sum    = 10'(i_item.red) + 10'(i_item.green) + 10'(i_item.blue);
    assign n_sq   = 20'(sum) * 20'(sum);
    assign n_g153 = 16'(FULL - i_item.green) * 16'(UV_TINT);
    assign n_b153 = 16'(FULL - i_item.blue) * 16'(UV_TINT);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_g153 <= n_g153;
            r_b153 <= n_b153;
        end
    end

    // Stage two: divide by reciprocal multiply, then apply the layer rule
    assign sq_prod = 41'(r_sq) * 41'(SQ_RECIP);
    assign g_prod  = 33'(r_g153) * 33'(UV_RECIP);
    assign b_prod  = 33'(r_b153) * 33'(UV_RECIP);
    assign quot    = sq_prod[39:32];
    assign fade    = FULL - quot;
    assign uv_g    = g_prod[31:24];
    assign uv_b    = b_prod[31:24];
    assign dark    = (sum < DARK_SUM);

    always_comb begin
        px = i_px;
        unique case (i_item.layer)
            LAYER_COLOR: begin
                px.red   = i_item.red;
                px.green = i_item.green;
                px.blue  = i_item.blue;
                if (i_cfg.transparent_preview && (fade < i_px.alpha)) begin
                    px.alpha = fade;
                end
            end
            LAYER_BLACK: begin
                if (dark && (i_item.alpha > BLACK_MIN_A)) begin
                    px = '{alpha: FULL, blue: 8'h00, green: 8'h00, red: 8'h00};
                end
            end
            LAYER_INHIBIT: begin
                if (dark) begin
                    px.alpha = 8'h00;
                end
            end
            LAYER_UV: begin
                if (i_cfg.uv_without_ink) begin
                    px.red   = FULL - i_item.red;
                    px.green = uv_g;
                    px.blue  = uv_b;
                    if (i_px.alpha > UV_ALPHA_CAP) begin
                        px.alpha = UV_ALPHA_CAP;
                    end
                end else if (dark) begin
                    px.red   = FULL;
                    px.green = UV_TINT;
                    px.blue  = UV_TINT;
                end
            end
            default: px = i_px;
        endcase
    end

    assign o_px = px;

endmodule

[sim/pixel_result_checker.sv]
// Checker for the pixel compositor: mirrors the frame store, predicts each result and compares.
`timescale 1ns / 1ps
module pixel_result_checker
    import clpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic      i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);

    // Brightness divisor for the transparent colour preview
    localparam int BRIGHT_DIV = 2295;

    t_pixel pixel_mirror [bit [ADDR_W-1:0]];
    t_pixel expected_pixels [$];
    t_cfg   cfg_copy;
    int     fails;

    // Scale an inverted channel into the UV tint range
    function automatic logic [7:0] uv_tint(logic [7:0] chan);
        int scaled;
        scaled = (int'(FULL) - int'(chan)) * int'(UV_TINT) / int'(FULL);
        return scaled[7:0];
    endfunction

    // Blend one source pixel onto a stored pixel according to its layer
    function automatic t_pixel composite_pixel(t_pixel px, t_in_item it, t_cfg cfg);
        t_pixel     res;
        logic [9:0] sum;
        int         sq_sum;
        int         fade;
        res = px;
        sum = {2'b00, it.red} + {2'b00, it.green} + {2'b00, it.blue};
        case (it.layer)
            LAYER_COLOR: begin
                res.red   = it.red;
                res.green = it.green;
                res.blue  = it.blue;
                if (cfg.transparent_preview) begin
                    sq_sum = int'(sum) * int'(sum);
                    fade   = int'(FULL) - sq_sum / BRIGHT_DIV;
                    if (fade < int'(px.alpha)) begin
                        res.alpha = fade[7:0];
                    end
                end
            end
            LAYER_BLACK: begin
                if (sum < DARK_SUM && it.alpha > BLACK_MIN_A) begin
                    res.red   = 8'h00;
                    res.green = 8'h00;
                    res.blue  = 8'h00;
                    res.alpha = FULL;
                end
            end
            LAYER_INHIBIT: begin
                if (sum < DARK_SUM) begin
                    res.alpha = 8'h00;
                end
            end
            default: begin
                // ultraviolet
                if (cfg.uv_without_ink) begin
                    res.red   = FULL - it.red;
                    res.green = uv_tint(it.green);
                    res.blue  = uv_tint(it.blue);
                    if (px.alpha > UV_ALPHA_CAP) begin
                        res.alpha = UV_ALPHA_CAP;
                    end
                end else if (sum < DARK_SUM) begin
                    res.red   = FULL;
                    res.green = UV_TINT;
                    res.blue  = UV_TINT;
                end
            end
        endcase
        return res;
    endfunction

    // Update the mirror with one item and return the pixel it leaves behind
    function automatic t_pixel apply_item(t_in_item it);
        t_pixel px;
        px = '0;
        if (int'(it.pixel_index) < FRAME_PIXELS) begin
            if (pixel_mirror.exists(it.pixel_index)) begin
                px = pixel_mirror[it.pixel_index];
            end
            if (it.op == OP_WRITE) begin
                px = {it.alpha, it.blue, it.green, it.red};
            end else if (it.op == OP_COMPOSITE) begin
                px = composite_pixel(px, it, cfg_copy);
            end
            pixel_mirror[it.pixel_index] = px;
        end
        return px;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (!i_rst_n) begin
            cfg_copy = '0;
        end else begin
            // Retire first: a result never belongs to an item taken at this same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with nothing expected: %h", i_out_item);
                    fails++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_red", want.red, i_out_item.out_red);
                    check_field("out_green", want.green, i_out_item.out_green);
                    check_field("out_blue", want.blue, i_out_item.out_blue);
                    check_field("out_alpha", want.alpha, i_out_item.out_alpha);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(apply_item(i_in_item));
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TRANSPARENT) begin
                    cfg_copy.transparent_preview = i_cfg_data;
                end else begin
                    cfg_copy.uv_without_ink = i_cfg_data;
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fails;
    end

endmodule

[sim/tb.sv]
// Testbench top: drives template, composite and read traffic and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import clpc_pkg::*;

    localparam int         POOL_SIZE        = 48;
    localparam int         PHASE_ITEMS      = 150;
    localparam int         BURST_ITEMS      = 40;
    localparam int         SINK_HOLD_CYCLES = 300;
    localparam int         DRAIN_CYCLES     = 10;
    localparam int         CYCLE_LIMIT      = 400000;
    localparam logic [1:0] OP_SPARE         = 2'd3;   // unused code, acts as a read

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_index = 1'b0;
    logic      i_cfg_data  = 1'b0;
    int        fail_count;
    int        pending;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    bit                written [POOL_SIZE];
    int                last_slot     = 0;
    bit                calm          = 1'b0;
    bit                sink_hold_req = 1'b0;
    int                op_seen [4];
    int                layer_seen [4];
    int                settings_done = 0;

    card_layer_pixel_compositor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pixel_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short idles, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lean toward dark and extreme channel values to hit the brightness thresholds
    function automatic logic [7:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return 8'($urandom_range(0, 127));
        if (roll < 40) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one item, hold it until the transfer
    task automatic issue(logic [1:0] op, logic [1:0] layer, int slot,
                         logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        t_in_item it;
        int       gap;
        it.op          = op;
        it.layer       = layer;
        it.pixel_index = addr_pool[slot];
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        it.alpha       = a;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_WRITE) written[slot] = 1'b1;
        op_seen[op]++;
        if (op == OP_COMPOSITE) layer_seen[layer]++;
        last_slot = slot;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(logic transparent, logic no_ink);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TRANSPARENT;
        i_cfg_data  <= transparent;
        @(posedge i_clk);
        i_cfg_index <= CFG_UV_NO_INK;
        i_cfg_data  <= no_ink;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_done++;
    endtask

    // Random item, always onto a pixel that has a template behind it
    task automatic random_item();
        int         slot;
        int         roll;
        logic [1:0] op;
        logic [7:0] a;
        slot = ($urandom_range(0, 2) == 0) ? last_slot : $urandom_range(0, POOL_SIZE - 1);
        roll = $urandom_range(0, 99);
        if (roll < 15 || !written[slot]) begin
            op = OP_WRITE;
        end else if (roll < 80) begin
            op = OP_COMPOSITE;
        end else begin
            op = ($urandom_range(0, 1) != 0) ? OP_READ : OP_SPARE;
        end
        if ($urandom_range(0, 4) == 0) a = 8'($urandom_range(127, 130));
        else a = 8'($urandom_range(0, 255));
        issue(op, 2'($urandom_range(0, 3)), slot, pick_channel(), pick_channel(),
              pick_channel(), a);
    endtask

    // Result side: random stalls, calm stretches, and one long hold on request
    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                if (!calm && $urandom_range(0, 4) == 0) stall = pick_gap();
                i_out_ready <= (stall == 0);
            end
        end
    end

    // Cycle limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("** card_layer_pixel_compositor_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = ADDR_W'($urandom_range(0, FRAME_PIXELS - 1));
            written[i]   = 1'b0;
        end
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = ADDR_W'(FRAME_PIXELS / 2);
        addr_pool[3] = ADDR_W'(FRAME_PIXELS / 2 - 1);
        for (int i = 0; i < 4; i++) begin
            op_seen[i]    = 0;
            layer_seen[i] = 0;
        end

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(1'b0, 1'b0);

        // Directed: templates at the address extremes, reads with both read codes
        issue(OP_WRITE, LAYER_COLOR, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_WRITE, LAYER_UV, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        issue(OP_READ, LAYER_BLACK, 1, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_SPARE, LAYER_UV, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Colour without preview keeps alpha
        issue(OP_COMPOSITE, LAYER_COLOR, 1, 8'h12, 8'h34, 8'h56, 8'h00);
        // Black just below the dark sum with alpha just above the minimum
        issue(OP_COMPOSITE, LAYER_BLACK, 1, 8'd127, 8'd128, 8'd128, 8'd129);
        issue(OP_WRITE, LAYER_COLOR, 2, 8'hAA, 8'h55, 8'hF0, 8'hC8);
        // Black rejected by alpha at the minimum, then by the sum at the threshold
        issue(OP_COMPOSITE, LAYER_BLACK, 2, 8'd127, 8'd128, 8'd128, 8'd128);
        issue(OP_COMPOSITE, LAYER_BLACK, 2, 8'd128, 8'd128, 8'd128, 8'hFF);
        // Inhibit at and just below the threshold
        issue(OP_COMPOSITE, LAYER_INHIBIT, 2, 8'd128, 8'd128, 8'd128, 8'hFF);
        issue(OP_COMPOSITE, LAYER_INHIBIT, 2, 8'd127, 8'd128, 8'd128, 8'hFF);
        // UV with ink layers: dark paints the tint, bright leaves the pixel
        issue(OP_COMPOSITE, LAYER_UV, 2, 8'd128, 8'd127, 8'd128, 8'h00);
        issue(OP_COMPOSITE, LAYER_UV, 1, 8'd128, 8'd128, 8'd128, 8'h00);
        issue(OP_WRITE, LAYER_BLACK, 3, 8'h01, 8'h02, 8'h03, 8'hFF);

        set_config(1'b1, 1'b1);
        // Preview: black source leaves alpha, white source clears it, mid grey lowers it
        issue(OP_COMPOSITE, LAYER_COLOR, 3, 8'h00, 8'h00, 8'h00, 8'hFF);
        issue(OP_COMPOSITE, LAYER_COLOR, 3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        issue(OP_WRITE, LAYER_INHIBIT, 1, 8'h10, 8'h20, 8'h30, 8'hFF);
        issue(OP_COMPOSITE, LAYER_COLOR, 1, 8'd100, 8'd100, 8'd100, 8'h00);
        // UV without ink: both source extremes, alpha cap above and below
        issue(OP_COMPOSITE, LAYER_UV, 1, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_COMPOSITE, LAYER_UV, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        issue(OP_COMPOSITE, LAYER_UV, 2, 8'h80, 8'h7F, 8'h01, 8'h80);
        issue(OP_COMPOSITE, LAYER_BLACK, 3, 8'h00, 8'h00, 8'h00, 8'hFF);

        // Random phases, one register setting each
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(1'b1, 1'b0);
                1: set_config(1'b0, 1'b1);
                2: set_config(1'b1, 1'b1);
                3: set_config(1'b0, 1'b0);
                default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            calm = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back-to-back burst against a long result hold: fill the pipe
                if (phase == 1 && n == PHASE_ITEMS / 2) begin
                    calm          = 1'b1;
                    sink_hold_req = 1'b1;
                end
                if (phase == 1 && n == PHASE_ITEMS / 2 + BURST_ITEMS) calm = 1'b0;
                random_item();
            end
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d template writes, %0d composites, %0d reads over %0d settings;",
                 op_seen[OP_WRITE], op_seen[OP_COMPOSITE],
                 op_seen[OP_READ] + op_seen[OP_SPARE], settings_done);
        $display("composites by layer colour/black/inhibit/uv: %0d/%0d/%0d/%0d, %0d errors.",
                 layer_seen[LAYER_COLOR], layer_seen[LAYER_BLACK],
                 layer_seen[LAYER_INHIBIT], layer_seen[LAYER_UV], fail_count);
        if (fail_count == 0) begin
            $display("** card_layer_pixel_compositor_top: PASSED **");
        end else begin
            $display("** card_layer_pixel_compositor_top: FAILED **");
        end
        $finish;
    end

endmodule
